// ===== src/crab_pkg.sv =====
// shared constants and helper functions for the clipped rectangle alpha blend unit
// register map, reset values, span clipping and the divide-by-255 helper
// no dependencies
`default_nettype none

package crab_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_RECT_LEFT    = 3'd0;
	localparam logic [2:0] REG_RECT_TOP     = 3'd1;
	localparam logic [2:0] REG_RECT_WIDTH   = 3'd2;
	localparam logic [2:0] REG_RECT_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_FILL_COLOR   = 3'd4;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;
	localparam logic [2:0] REG_BLEND_MODE   = 3'd7;

	localparam int          MAX_DIM_DEF     = 4096;
	localparam int          ADDR_W          = 5;
	localparam int          DIM_W           = 13;
	localparam int          POS_W           = 12;
	localparam int          SPAN_W          = 15;
	localparam logic [12:0] FRAME_DIM_RST   = 13'd4096;
	localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;
	localparam logic [7:0]  ALPHA_CLEAR     = 8'h00;

	// true when pos lies in [max(start,0), min(start+len, bound))
	function automatic logic in_span(
		input logic [POS_W-1:0] pos,
		input logic signed [DIM_W-1:0] start,
		input logic [DIM_W-1:0] len,
		input logic [DIM_W-1:0] bound
	);
		logic signed [SPAN_W-1:0] lo;
		logic signed [SPAN_W-1:0] hi;
		logic signed [SPAN_W-1:0] bnd;
		logic signed [SPAN_W-1:0] p;
		lo  = start[DIM_W-1] ? '0 : SPAN_W'(start);
		hi  = SPAN_W'(start) + $signed({2'b00, len});
		bnd = $signed({2'b00, bound});
		p   = $signed({3'b000, pos});
		if (hi > bnd) begin
			hi = bnd;
		end
		return (p >= lo) && (p < hi);
	endfunction

	// exact floor(x / 255) for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// ===== src/clipped_rect_alpha_blend_unit.sv =====
// clipped rectangle fill / source-over alpha blend on a pixel stream
// three-stage pipeline with an apb-style register port
// depends on crab_pkg
`default_nettype none

// an accepted input transaction passes through s1, s2 and s3 before its output transaction
// throughput: one pixel per cycle while out_stall is low; each stage holds one pixel and
//   moves on when the stage after it is empty or advancing, so stalls hold data without loss
// stages: s1 clip test and mode decision, s2 per-channel multiply-add, s3 divide by 255
// reset: pipeline valid bits clear, registers take their reset values (frame 4096x4096,
//   empty rectangle, fill mode); no clearing pass, input accepted from the first edge after release
module clipped_rect_alpha_blend_unit #(
	parameter int MAX_DIM = crab_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// apb-style configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [crab_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output      logic [31:0]                   prdata,
	output      logic                          pready,

	// pixel input channel
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [crab_pkg::POS_W-1:0]    pixel_column,
	input  wire logic [crab_pkg::POS_W-1:0]    pixel_row,
	input  wire logic [31:0]                   dest_pixel,

	// pixel output channel
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [31:0]                   pixel_out,
	output      logic                          pixel_written
);

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	logic signed [crab_pkg::DIM_W-1:0] rect_left_q;
	logic signed [crab_pkg::DIM_W-1:0] rect_top_q;
	logic [crab_pkg::DIM_W-1:0]        rect_width_q;
	logic [crab_pkg::DIM_W-1:0]        rect_height_q;
	logic [31:0]                       fill_color_q;
	logic [crab_pkg::DIM_W-1:0]        frame_width_q;
	logic [crab_pkg::DIM_W-1:0]        frame_height_q;
	logic                              blend_mode_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[crab_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q    <= '0;
			rect_top_q     <= '0;
			rect_width_q   <= '0;
			rect_height_q  <= '0;
			fill_color_q   <= '0;
			frame_width_q  <= crab_pkg::FRAME_DIM_RST;
			frame_height_q <= crab_pkg::FRAME_DIM_RST;
			blend_mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				crab_pkg::REG_RECT_LEFT:    rect_left_q    <= $signed(pwdata[12:0]);
				crab_pkg::REG_RECT_TOP:     rect_top_q     <= $signed(pwdata[12:0]);
				crab_pkg::REG_RECT_WIDTH:   rect_width_q   <= pwdata[12:0];
				crab_pkg::REG_RECT_HEIGHT:  rect_height_q  <= pwdata[12:0];
				crab_pkg::REG_FILL_COLOR:   fill_color_q   <= pwdata;
				crab_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[12:0];
				crab_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
				crab_pkg::REG_BLEND_MODE:   blend_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			crab_pkg::REG_RECT_LEFT:    prdata = {19'd0, rect_left_q};
			crab_pkg::REG_RECT_TOP:     prdata = {19'd0, rect_top_q};
			crab_pkg::REG_RECT_WIDTH:   prdata = {19'd0, rect_width_q};
			crab_pkg::REG_RECT_HEIGHT:  prdata = {19'd0, rect_height_q};
			crab_pkg::REG_FILL_COLOR:   prdata = fill_color_q;
			crab_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_q};
			crab_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_q};
			crab_pkg::REG_BLEND_MODE:   prdata = {31'd0, blend_mode_q};
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// pipeline flow control
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	// a stage loads when it is empty or its content moves on this edge
	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------------
	// stage 1: clip test against rectangle and saturated frame bounds
	// ---------------------------------------------------------------------
	logic [crab_pkg::DIM_W-1:0] bound_x, bound_y;
	logic                       in_rect;
	logic [7:0]                 alpha;

	// frame size above MAX_DIM clips at MAX_DIM
	assign bound_x = ({19'd0, frame_width_q} > 32'(MAX_DIM))  ? crab_pkg::DIM_W'(MAX_DIM)
	                                                          : frame_width_q;
	assign bound_y = ({19'd0, frame_height_q} > 32'(MAX_DIM)) ? crab_pkg::DIM_W'(MAX_DIM)
	                                                          : frame_height_q;
	assign alpha   = fill_color_q[31:24];
	assign in_rect = crab_pkg::in_span(pixel_column, rect_left_q, rect_width_q, bound_x) &&
	                 crab_pkg::in_span(pixel_row, rect_top_q, rect_height_q, bound_y);

	logic [31:0] dst_s1;
	logic        full_s1;   // replace with the fill colour
	logic        blend_s1;  // mix with the fill colour

	always_ff @(posedge clk) begin
		if (en1) begin
			dst_s1   <= dest_pixel;
			full_s1  <= in_rect && (!blend_mode_q || alpha == crab_pkg::ALPHA_OPAQUE);
			blend_s1 <= in_rect && blend_mode_q && alpha != crab_pkg::ALPHA_OPAQUE &&
			            alpha != crab_pkg::ALPHA_CLEAR;
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: src*a + dst*(255-a) for each colour channel
	// ---------------------------------------------------------------------
	logic [7:0]  inv_alpha;
	logic [15:0] mix_r, mix_g, mix_b;

	assign inv_alpha = crab_pkg::ALPHA_OPAQUE - alpha;
	assign mix_r = fill_color_q[23:16] * alpha + dst_s1[23:16] * inv_alpha;
	assign mix_g = fill_color_q[15:8]  * alpha + dst_s1[15:8]  * inv_alpha;
	assign mix_b = fill_color_q[7:0]   * alpha + dst_s1[7:0]   * inv_alpha;

	logic [31:0] dst_s2;
	logic        full_s2, blend_s2;
	logic [15:0] mix_r_s2, mix_g_s2, mix_b_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			dst_s2   <= dst_s1;
			full_s2  <= full_s1;
			blend_s2 <= blend_s1;
			mix_r_s2 <= mix_r;
			mix_g_s2 <= mix_g;
			mix_b_s2 <= mix_b;
		end
	end

	// ---------------------------------------------------------------------
	// stage 3: divide by 255 and pick the result
	// ---------------------------------------------------------------------
	logic [31:0] blended;
	logic [31:0] pixel_s3;
	logic        written_s3;

	assign blended = {crab_pkg::ALPHA_OPAQUE, crab_pkg::div255(mix_r_s2),
	                  crab_pkg::div255(mix_g_s2), crab_pkg::div255(mix_b_s2)};

	always_ff @(posedge clk) begin
		if (en3) begin
			pixel_s3   <= full_s2 ? fill_color_q : (blend_s2 ? blended : dst_s2);
			written_s3 <= full_s2 || blend_s2;
		end
	end

	assign out_valid     = v_s3;
	assign pixel_out     = pixel_s3;
	assign pixel_written = written_s3;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------

	// input is held back only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with an empty pipeline stage");

	// fill and blend decisions are exclusive
	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(full_s1 && blend_s1))
		else $error("pixel marked for both fill and blend");

	// a blended pixel always comes out opaque
	a_blend_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_written && blend_mode_q)
		|-> (pixel_out[31:24] == crab_pkg::ALPHA_OPAQUE))
		else $error("blended pixel is not opaque");

	// a transparent fill colour in blend mode never writes
	a_clear_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && blend_mode_q && fill_color_q[31:24] == crab_pkg::ALPHA_CLEAR)
		|-> !pixel_written)
		else $error("transparent blend wrote a pixel");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for clipped_rect_alpha_blend_unit: directed table, then random pixels
// with per-phase register settings, predicted by an in-bench clip and blend model
// depends on crab_pkg and the unit under test
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// clipping bound saturates here, same as the unit's default size
	localparam int FRAME_LIMIT = crab_pkg::MAX_DIM_DEF;
	// cycles without any accepted transaction before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// receiver hold-off used to fill the pipeline and back-pressure the input
	localparam int HOLD_CYCLES = 64;
	localparam int RANDOM_PHASES = 12;
	localparam int PIXELS_PER_PHASE = 125;

	typedef struct packed {
		logic [31:0] value;
		logic        written;
	} pix_result_t;

	// one full register setting
	typedef struct packed {
		logic [12:0] left;
		logic [12:0] top;
		logic [12:0] width;
		logic [12:0] height;
		logic [31:0] color;
		logic [12:0] fw;
		logic [12:0] fh;
		logic        blend;
	} cfg_set_t;

	// directed stimulus row; typed rows carry their expected result
	typedef struct packed {
		logic [3:0]  cfg_sel;
		logic [11:0] col;
		logic [11:0] row;
		logic [31:0] dest;
		logic        typed;
		logic [31:0] exp_value;
		logic        exp_written;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [crab_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [crab_pkg::POS_W-1:0] pixel_column = '0;
	logic [crab_pkg::POS_W-1:0] pixel_row = '0;
	logic [31:0] dest_pixel = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] pixel_out;
	logic        pixel_written;

	// register copies seen by the predictor, reset values to start with
	logic signed [12:0] cf_left = '0;
	logic signed [12:0] cf_top = '0;
	logic [12:0] cf_width = '0;
	logic [12:0] cf_height = '0;
	logic [31:0] cf_color = '0;
	logic [12:0] cf_fw = crab_pkg::FRAME_DIM_RST;
	logic [12:0] cf_fh = crab_pkg::FRAME_DIM_RST;
	logic        cf_blend = 1'b0;

	// expectation attached to the pixel currently offered
	logic        cur_typed = 1'b0;
	pix_result_t cur_typed_res = '0;

	pix_result_t expected_pixels[$];
	int          error_count = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	bit          pressure_req = 1'b0;

	// register settings used by the directed table
	cfg_set_t cfg_sets[11] = '{
		// reset values: empty rectangle, nothing inside
		'{13'd0, 13'd0, 13'd0, 13'd0, 32'h00000000, 13'd4096, 13'd4096, 1'b0},
		// fill, rectangle hanging off the top left corner
		'{13'h1FFD, 13'h1FFD, 13'd10, 13'd10, 32'hA1B2C3D4, 13'd4096, 13'd4096, 1'b0},
		// blend with opaque alpha, oversized frame saturates
		'{13'd0, 13'd0, 13'd8191, 13'd8191, 32'hFF102030, 13'd8191, 13'd8191, 1'b1},
		// blend with clear alpha
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'h00FFFFFF, 13'd4096, 13'd4096, 1'b1},
		// blend with half alpha
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'h80FF0000, 13'd4096, 13'd4096, 1'b1},
		// zero frame width
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'h12345678, 13'd0, 13'd4096, 1'b0},
		// single pixel in the far corner
		'{13'd4095, 13'd4095, 13'd1, 13'd1, 32'h55AA55AA, 13'd4096, 13'd4096, 1'b0},
		// most negative origin with widest span
		'{13'h1000, 13'h1000, 13'd8191, 13'd8191, 32'h00000000, 13'd4096, 13'd4096, 1'b0},
		// blend with the smallest nonzero alpha
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'h01ABCDEF, 13'd4096, 13'd4096, 1'b1},
		// zero frame height
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'h9ABCDEF0, 13'd4096, 13'd0, 1'b0},
		// blend with the largest non-opaque alpha
		'{13'd0, 13'd0, 13'd4096, 13'd4096, 32'hFE00FF80, 13'd4096, 13'd4096, 1'b1}
	};

	localparam int DIR_ROWS = 25;
	dir_row_t dir_rows[DIR_ROWS] = '{
		'{4'd0, 12'd0, 12'd0, 32'h12345678, 1'b1, 32'h12345678, 1'b0},
		'{4'd0, 12'd4095, 12'd4095, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
		'{4'd1, 12'd0, 12'd0, 32'hDEADBEEF, 1'b1, 32'hA1B2C3D4, 1'b1},
		'{4'd1, 12'd6, 12'd6, 32'h00000000, 1'b1, 32'hA1B2C3D4, 1'b1},
		'{4'd1, 12'd7, 12'd0, 32'hCAFEF00D, 1'b1, 32'hCAFEF00D, 1'b0},
		'{4'd1, 12'd0, 12'd7, 32'h01020304, 1'b1, 32'h01020304, 1'b0},
		'{4'd2, 12'd4095, 12'd4095, 32'h00000000, 1'b1, 32'hFF102030, 1'b1},
		'{4'd2, 12'd0, 12'd0, 32'hFFFFFFFF, 1'b1, 32'hFF102030, 1'b1},
		'{4'd3, 12'd100, 12'd200, 32'h87654321, 1'b1, 32'h87654321, 1'b0},
		'{4'd3, 12'd4095, 12'd0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
		'{4'd4, 12'd0, 12'd0, 32'h00000000, 1'b0, 32'h0, 1'b0},
		'{4'd4, 12'd1, 12'd1, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd4, 12'd2, 12'd3, 32'h7F3C9A11, 1'b0, 32'h0, 1'b0},
		'{4'd5, 12'd0, 12'd0, 32'h11111111, 1'b1, 32'h11111111, 1'b0},
		'{4'd5, 12'd4095, 12'd4095, 32'h22222222, 1'b1, 32'h22222222, 1'b0},
		'{4'd6, 12'd4095, 12'd4095, 32'h00000000, 1'b1, 32'h55AA55AA, 1'b1},
		'{4'd6, 12'd4094, 12'd4095, 32'h33333333, 1'b1, 32'h33333333, 1'b0},
		'{4'd6, 12'd4095, 12'd4094, 32'h44444444, 1'b1, 32'h44444444, 1'b0},
		'{4'd7, 12'd4094, 12'd4094, 32'hABCDEF01, 1'b1, 32'h00000000, 1'b1},
		'{4'd7, 12'd4095, 12'd0, 32'hABCDEF01, 1'b1, 32'hABCDEF01, 1'b0},
		'{4'd8, 12'd10, 12'd10, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd8, 12'd11, 12'd11, 32'h00FF00FF, 1'b0, 32'h0, 1'b0},
		'{4'd9, 12'd0, 12'd0, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b0},
		'{4'd10, 12'd0, 12'd0, 32'h80808080, 1'b0, 32'h0, 1'b0},
		'{4'd10, 12'd2047, 12'd2048, 32'h0F1E2D3C, 1'b0, 32'h0, 1'b0}
	};

	clipped_rect_alpha_blend_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.dest_pixel   (dest_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.pixel_written(pixel_written)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// position lies in [max(start,0), min(start+len, bound)), bound saturating
	function automatic bit span_hit(int pos, int start, int len, int bound);
		int lo;
		int hi;
		int lim;
		lo = (start < 0) ? 0 : start;
		lim = (bound > FRAME_LIMIT) ? FRAME_LIMIT : bound;
		hi = start + len;
		if (hi > lim) begin
			hi = lim;
		end
		return (pos >= lo) && (pos < hi);
	endfunction

	// source-over mix of one channel, truncated
	function automatic logic [7:0] mix_channel(int src, int dst, int a);
		return 8'((src * a + dst * (255 - a)) / 255);
	endfunction

	// expected result of one pixel under the current register copies
	function automatic pix_result_t blend_pixel(logic [11:0] col, logic [11:0] row,
			logic [31:0] dest);
		pix_result_t r;
		logic [7:0] a;
		int ch;
		r.value = dest;
		r.written = 1'b0;
		a = cf_color[31:24];
		if (span_hit(int'(col), int'(cf_left), int'(cf_width), int'(cf_fw)) &&
				span_hit(int'(row), int'(cf_top), int'(cf_height), int'(cf_fh))) begin
			if (!cf_blend || a == crab_pkg::ALPHA_OPAQUE) begin
				r.value = cf_color;
				r.written = 1'b1;
			end else if (a != crab_pkg::ALPHA_CLEAR) begin
				r.value[31:24] = crab_pkg::ALPHA_OPAQUE;
				for (ch = 0; ch < 3; ch++) begin
					r.value[ch*8 +: 8] = mix_channel(cf_color[ch*8 +: 8], dest[ch*8 +: 8], a);
				end
				r.written = 1'b1;
			end
		end
		return r;
	endfunction

	// origin: near zero, anywhere, zero, or at the far edge
	function automatic logic [12:0] pick_origin();
		case ($urandom_range(3))
			0: return 13'($urandom_range(40) - 20);
			1: return 13'($urandom);
			2: return '0;
			default: return 13'($urandom_range(4095, 4000));
		endcase
	endfunction

	// rectangle size: small half the time so both sides of each edge get hit
	function automatic logic [12:0] pick_size();
		case ($urandom_range(3))
			0: return 13'($urandom_range(64));
			1: return 13'($urandom);
			2: return 13'(FRAME_LIMIT);
			default: return 13'($urandom_range(8, 1));
		endcase
	endfunction

	// frame size: full, partial, any 13-bit value, or tiny
	function automatic logic [12:0] pick_frame();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) begin
			return 13'(FRAME_LIMIT);
		end else if (sel < 8) begin
			return 13'($urandom_range(4096, 1));
		end else if (sel == 8) begin
			return 13'($urandom);
		end
		return 13'($urandom_range(64, 1));
	endfunction

	function automatic cfg_set_t random_config();
		cfg_set_t c;
		logic [7:0] a;
		c.left = pick_origin();
		c.top = pick_origin();
		c.width = pick_size();
		c.height = pick_size();
		c.fw = pick_frame();
		c.fh = pick_frame();
		case ($urandom_range(5))
			0: a = crab_pkg::ALPHA_CLEAR;
			1: a = 8'h01;
			2: a = 8'h80;
			3: a = 8'hFE;
			4: a = crab_pkg::ALPHA_OPAQUE;
			default: a = 8'($urandom);
		endcase
		c.color = {a, 24'($urandom)};
		c.blend = 1'($urandom_range(1));
		return c;
	endfunction

	// pixel coordinate: anywhere, around the near edge, or around the far edge
	function automatic logic [11:0] pick_pos(logic signed [12:0] start, logic [12:0] len);
		int lo;
		int reach;
		lo = (start < 0) ? 0 : int'(start);
		reach = (len > 64) ? 64 : int'(len);
		case ($urandom_range(2))
			0: return 12'($urandom);
			1: return 12'(lo + int'($urandom_range(reach + 2)) - 1);
			default: return 12'(int'(start) + int'(len) + int'($urandom_range(6)) - 3);
		endcase
	endfunction

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			crab_pkg::REG_RECT_LEFT:    cf_left = val[12:0];
			crab_pkg::REG_RECT_TOP:     cf_top = val[12:0];
			crab_pkg::REG_RECT_WIDTH:   cf_width = val[12:0];
			crab_pkg::REG_RECT_HEIGHT:  cf_height = val[12:0];
			crab_pkg::REG_FILL_COLOR:   cf_color = val;
			crab_pkg::REG_FRAME_WIDTH:  cf_fw = val[12:0];
			crab_pkg::REG_FRAME_HEIGHT: cf_fh = val[12:0];
			crab_pkg::REG_BLEND_MODE:   cf_blend = val[0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_config(input cfg_set_t c);
		write_reg(crab_pkg::REG_RECT_LEFT, 32'(c.left));
		write_reg(crab_pkg::REG_RECT_TOP, 32'(c.top));
		write_reg(crab_pkg::REG_RECT_WIDTH, 32'(c.width));
		write_reg(crab_pkg::REG_RECT_HEIGHT, 32'(c.height));
		write_reg(crab_pkg::REG_FILL_COLOR, c.color);
		write_reg(crab_pkg::REG_FRAME_WIDTH, 32'(c.fw));
		write_reg(crab_pkg::REG_FRAME_HEIGHT, 32'(c.fh));
		write_reg(crab_pkg::REG_BLEND_MODE, 32'(c.blend));
	endtask

	// offer one pixel transaction, with random idle cycles first, until accepted
	task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
			input logic [31:0] dest, input logic typed, input pix_result_t typed_res);
		@(negedge clk);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_column <= col;
		pixel_row <= row;
		dest_pixel <= dest;
		cur_typed <= typed;
		cur_typed_res <= typed_res;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// stop offering and wait until every predicted pixel has come out
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stalls per phase, plus a counted hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	// scoreboard: predict at input acceptance, compare at output acceptance
	always @(posedge clk) begin : scoreboard
		pix_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					error_count++;
					$display("%0t: result with nothing expected: out=%08h written=%0b",
						$time, pixel_out, pixel_written);
				end else begin
					e = expected_pixels.pop_front();
					if (e.value !== pixel_out || e.written !== pixel_written) begin
						error_count++;
						$display("%0t: pixel mismatch: expected out=%08h written=%0b, %s%08h %s%0b",
							$time, e.value, e.written, "actual out=", pixel_out,
							"written=", pixel_written);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cur_typed) begin
					expected_pixels.push_back(cur_typed_res);
				end else begin
					expected_pixels.push_back(blend_pixel(pixel_column, pixel_row, dest_pixel));
				end
			end
		end
	end

	// watchdog: cycles with no accepted transaction on either channel
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		int ph;
		int k;
		int applied;

		// reset once
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, no idling; registers change only with the pipeline empty
		applied = 0;
		for (i = 0; i < DIR_ROWS; i++) begin
			if (int'(dir_rows[i].cfg_sel) != applied) begin
				drain_pipeline();
				apply_config(cfg_sets[dir_rows[i].cfg_sel]);
				applied = int'(dir_rows[i].cfg_sel);
			end
			send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].dest, dir_rows[i].typed,
				'{dir_rows[i].exp_value, dir_rows[i].exp_written});
		end

		// random phases, each with its own setting and idling pattern
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_pipeline();
			case (ph % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 56;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 56;
				end
				default: begin
					gap_pct = 37;
					stall_pct = 37;
				end
			endcase
			apply_config(random_config());
			// long receiver hold-off while the sender keeps offering
			if (ph == 4) begin
				pressure_req = 1'b1;
			end
			for (k = 0; k < PIXELS_PER_PHASE; k++) begin
				send_pixel(pick_pos(cf_left, cf_width), pick_pos(cf_top, cf_height),
					$urandom, 1'b0, '0);
			end
		end

		drain_pipeline();
		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
